// ===== rtl/segment_circle_intersection_macros.svh =====
// Assertion macros used by the checker.
`ifndef SEGMENT_CIRCLE_INTERSECTION_MACROS_SVH
`define SEGMENT_CIRCLE_INTERSECTION_MACROS_SVH

// antecedent implies consequent, same or later cycle
`define SCI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment_circle_intersection assertion failed");

// antecedent implies consequent in the next cycle
`define SCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment_circle_intersection assertion failed");

`endif

// ===== rtl/sci_pkg.sv =====
package sci_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * COORD_WIDTH + 2;
   localparam int SUM_W       = 2 * COORD_WIDTH + 3;
   localparam int C_W         = 2 * COORD_WIDTH + 4;
   localparam int RSQ_W       = 2 * COORD_WIDTH - 2;
   localparam int MAG_W       = 2 * COORD_WIDTH + 3;
   localparam int LO_W        = (MAG_W + 1) / 2;
   localparam int HI_W        = MAG_W - LO_W;
   localparam int FULL_W      = 2 * MAG_W + 1;
   localparam int LATENCY     = 7;

   typedef struct packed {
      logic valid;
      logic decided;
      logic early_hit;
      logic vertex_in;
   } sci_flags_type;

endpackage

// ===== rtl/sci_disc_unit.sv =====
module sci_disc_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  sci_pkg::sci_flags_type     flags,
   input  logic [sci_pkg::MAG_W-1:0]  bp_mag,
   input  logic [sci_pkg::MAG_W-1:0]  a_mag,
   input  logic [sci_pkg::MAG_W-1:0]  c_mag,
   output logic                       rsp_valid,
   output logic                       rsp_hit
);
   import sci_pkg::*;

   logic [HI_W-1:0] bh, ah, ch;
   logic [LO_W-1:0] bl, al, cl;

   sci_flags_type p_flags_ff, s_flags_ff;
   logic [2*HI_W-1:0]      b_hh_ff, ac_hh_ff;
   logic [HI_W+LO_W-1:0]   b_hl_ff, ac_hl_ff, ac_lh_ff;
   logic [2*LO_W-1:0]      b_ll_ff, ac_ll_ff;
   logic [FULL_W-1:0]      sq_ff, ac_ff, sq_in, ac_in;
   logic                   valid_ff, hit_ff, hit_in;

   assign bh = bp_mag[MAG_W-1:LO_W];
   assign bl = bp_mag[LO_W-1:0];
   assign ah = a_mag[MAG_W-1:LO_W];
   assign al = a_mag[LO_W-1:0];
   assign ch = c_mag[MAG_W-1:LO_W];
   assign cl = c_mag[LO_W-1:0];

   always_ff @(posedge clock) begin
      b_hh_ff  <= (2*HI_W)'(bh) * (2*HI_W)'(bh);
      b_hl_ff  <= (HI_W+LO_W)'(bh) * (HI_W+LO_W)'(bl);
      b_ll_ff  <= (2*LO_W)'(bl) * (2*LO_W)'(bl);
      ac_hh_ff <= (2*HI_W)'(ah) * (2*HI_W)'(ch);
      ac_hl_ff <= (HI_W+LO_W)'(ah) * (HI_W+LO_W)'(cl);
      ac_lh_ff <= (HI_W+LO_W)'(al) * (HI_W+LO_W)'(ch);
      ac_ll_ff <= (2*LO_W)'(al) * (2*LO_W)'(cl);
      sq_ff    <= sq_in;
      ac_ff    <= ac_in;
      hit_ff   <= hit_in;
   end

   always_comb begin
      sq_in = (FULL_W'(b_hh_ff) << (2*LO_W)) + (FULL_W'(b_hl_ff) << (LO_W+1))
            + FULL_W'(b_ll_ff);
      ac_in = (FULL_W'(ac_hh_ff) << (2*LO_W)) + (FULL_W'(ac_hl_ff) << LO_W)
            + (FULL_W'(ac_lh_ff) << LO_W) + FULL_W'(ac_ll_ff);
      hit_in = s_flags_ff.decided ? s_flags_ff.early_hit
                                  : (s_flags_ff.vertex_in && (sq_ff >= ac_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_flags_ff <= '0;
         s_flags_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         p_flags_ff <= flags;
         s_flags_ff <= p_flags_ff;
         valid_ff   <= s_flags_ff.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hit   = hit_ff;
endmodule

// ===== rtl/segment_circle_intersection.sv =====
// Segment / circle boundary crossing test.
// Command channel: present the circle (req_centre_x, req_centre_y,
// req_circle_radius) and the segment (req_start_*, req_end_*) and raise
// start; coordinates are signed Q16.16, the radius unsigned Q15.16. A word
// is taken at every rising edge with start high and busy low; busy is high
// only while reset is held, so one test can enter every cycle.
// Result channel: rsp_hit is shown for one cycle with rsp_valid high,
// in order of entry. Throughput is one test per cycle; the seven register
// stages are set by the 33x33 products, the 67- and 68-bit sums, the split
// 67x67 discriminant products and the final 135-bit compare.
// Reset clears every stage valid bit; tests in flight are dropped and
// rsp_valid stays low until new words come out of the pipeline.
// The receiver cannot stall, so no backpressure reaches the pipeline.
module segment_circle_intersection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_centre_x,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_centre_y,
   input  logic [sci_pkg::COORD_WIDTH-2:0]  req_circle_radius,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_start_x,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_start_y,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_end_x,
   input  logic [sci_pkg::COORD_WIDTH-1:0]  req_end_y,
   output logic                             rsp_valid,
   output logic                             rsp_hit
);
   import sci_pkg::*;

   localparam int W = COORD_WIDTH;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, fx_ff, fy_ff, gx_ff, gy_ff;
   logic [W-2:0]             r_ff;
   logic signed [PROD_W-1:0] dxx_ff, dyy_ff, fxd_ff, fyd_ff, fxx_ff, fyy_ff, gxx_ff, gyy_ff;
   logic [RSQ_W-1:0]         r2_ff;
   logic signed [SUM_W-1:0]  a_ff, bp_ff;
   logic signed [C_W-1:0]    c0_ff, c1_ff;
   logic signed [C_W-1:0]    apb;
   logic [SUM_W-1:0]         bp_neg_val;
   sci_flags_type            flags_ff, flags_in;
   logic [MAG_W-1:0]         bpm_ff, am_ff, cm_ff, bpm_in;

   assign busy = reset;

   function automatic logic signed [DIFF_W-1:0] sdiff(logic [W-1:0] p, logic [W-1:0] q);
      return $signed({p[W-1], p}) - $signed({q[W-1], q});
   endfunction

   always_ff @(posedge clock) begin
      dx_ff  <= sdiff(req_end_x, req_start_x);
      dy_ff  <= sdiff(req_end_y, req_start_y);
      fx_ff  <= sdiff(req_start_x, req_centre_x);
      fy_ff  <= sdiff(req_start_y, req_centre_y);
      gx_ff  <= sdiff(req_end_x, req_centre_x);
      gy_ff  <= sdiff(req_end_y, req_centre_y);
      r_ff   <= req_circle_radius;
      dxx_ff <= dx_ff * dx_ff;
      dyy_ff <= dy_ff * dy_ff;
      fxd_ff <= fx_ff * dx_ff;
      fyd_ff <= fy_ff * dy_ff;
      fxx_ff <= fx_ff * fx_ff;
      fyy_ff <= fy_ff * fy_ff;
      gxx_ff <= gx_ff * gx_ff;
      gyy_ff <= gy_ff * gy_ff;
      r2_ff  <= RSQ_W'(r_ff) * RSQ_W'(r_ff);
      a_ff   <= SUM_W'(dxx_ff) + SUM_W'(dyy_ff);
      bp_ff  <= SUM_W'(fxd_ff) + SUM_W'(fyd_ff);
      c0_ff  <= C_W'(fxx_ff) + C_W'(fyy_ff) - $signed(C_W'(r2_ff));
      c1_ff  <= C_W'(gxx_ff) + C_W'(gyy_ff) - $signed(C_W'(r2_ff));
      bpm_ff <= bpm_in;
      am_ff  <= MAG_W'(a_ff);
      cm_ff  <= MAG_W'(c0_ff);
   end

   always_comb begin
      apb        = C_W'(a_ff) + C_W'(bp_ff);
      bp_neg_val = -bp_ff;
      bpm_in     = bp_ff[SUM_W-1] ? MAG_W'(bp_neg_val) : MAG_W'(bp_ff);
      flags_in.valid     = v3_ff;
      flags_in.vertex_in = (bp_ff[SUM_W-1] || (bp_ff == '0)) && !apb[C_W-1];
      flags_in.decided   = 1'b1;
      flags_in.early_hit = 1'b0;
      if (a_ff == '0) begin
         flags_in.early_hit = 1'b0;
      end else if ((c0_ff == '0) || (c1_ff == '0)) begin
         flags_in.early_hit = 1'b1;
      end else if (c0_ff[C_W-1] != c1_ff[C_W-1]) begin
         flags_in.early_hit = 1'b1;
      end else if (c0_ff[C_W-1]) begin
         flags_in.early_hit = 1'b0;
      end else begin
         flags_in.decided = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         flags_ff <= '0;
      end else begin
         v1_ff    <= start && !busy;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         flags_ff <= flags_in;
      end
   end

   sci_disc_unit u_disc (
      .clock     (clock),
      .reset     (reset),
      .flags     (flags_ff),
      .bp_mag    (bpm_ff),
      .a_mag     (am_ff),
      .c_mag     (cm_ff),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit)
   );
endmodule

// ===== rtl/sci_checker.sv =====
`include "segment_circle_intersection_macros.svh"

module sci_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [sci_pkg::COORD_WIDTH-1:0]  req_start_x,
   input logic [sci_pkg::COORD_WIDTH-1:0]  req_start_y,
   input logic [sci_pkg::COORD_WIDTH-1:0]  req_end_x,
   input logic [sci_pkg::COORD_WIDTH-1:0]  req_end_y,
   input logic                             rsp_valid,
   input logic                             rsp_hit
);
   import sci_pkg::*;

   `SCI_ASSERT_IMPL(word_comes_out, clock, reset, start && !busy, ##LATENCY rsp_valid)
   `SCI_ASSERT_IMPL(no_stray_word, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   `SCI_ASSERT_IMPL(point_never_hits, clock, reset, start && !busy && (req_start_x == req_end_x) && (req_start_y == req_end_y), ##LATENCY !rsp_hit)
   `SCI_ASSERT_NEXT(never_busy, clock, reset, 1'b1, !busy)
endmodule

bind segment_circle_intersection sci_checker u_sci_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_start_x (req_start_x),
   .req_start_y (req_start_y),
   .req_end_x   (req_end_x),
   .req_end_y   (req_end_y),
   .rsp_valid   (rsp_valid),
   .rsp_hit     (rsp_hit)
);

// ===== sim/tb_segment_circle_intersection.sv =====
`timescale 1ns / 1ps

module tb_segment_circle_intersection;
   import sci_pkg::*;

   localparam int CW        = COORD_WIDTH;
   localparam int N_RANDOM  = 1800;
   localparam int WDOG_MAX  = 5000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [CW-2:0]        radius_type;
   typedef logic signed [255:0]  wide_type;

   typedef struct {
      coord_type  cx, cy;
      radius_type rad;
      coord_type  sx, sy, ex, ey;
      int         want;   // -1: use predictor
   } geo_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   coord_type  req_centre_x = '0, req_centre_y = '0;
   radius_type req_circle_radius = '0;
   coord_type  req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic       rsp_valid, rsp_hit;

   bit      expected_hits[$];
   int      errors = 0;
   int      idle_cycles = 0;

   segment_circle_intersection DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_centre_x(req_centre_x), .req_centre_y(req_centre_y),
      .req_circle_radius(req_circle_radius),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit)
   );

   always #5 clock = ~clock;

   function automatic bit crosses_boundary(geo_word_type w);
      wide_type dx, dy, fx, fy, gx, gy, r2, a, bp, c0, c1, disc;
      dx = wide_type'(w.ex) - wide_type'(w.sx);
      dy = wide_type'(w.ey) - wide_type'(w.sy);
      fx = wide_type'(w.sx) - wide_type'(w.cx);
      fy = wide_type'(w.sy) - wide_type'(w.cy);
      gx = wide_type'(w.ex) - wide_type'(w.cx);
      gy = wide_type'(w.ey) - wide_type'(w.cy);
      r2 = wide_type'({1'b0, w.rad}) * wide_type'({1'b0, w.rad});
      a  = dx * dx + dy * dy;
      bp = fx * dx + fy * dy;
      c0 = fx * fx + fy * fy - r2;
      c1 = gx * gx + gy * gy - r2;
      if (a == 0) return 1'b0;
      if (c0 == 0 || c1 == 0) return 1'b1;
      if ((c0 < 0) != (c1 < 0)) return 1'b1;
      if (c0 < 0) return 1'b0;
      disc = bp * bp - a * c0;
      return (disc >= 0) && (bp <= 0) && (a + bp >= 0);
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 'h4_0000)) - 'h2_0000);
         default: return coord_type'($signed($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   task automatic send_word(geo_word_type w);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_centre_x      <= w.cx;
      req_centre_y      <= w.cy;
      req_circle_radius <= w.rad;
      req_start_x       <= w.sx;
      req_start_y       <= w.sy;
      req_end_x         <= w.ex;
      req_end_y         <= w.ey;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (w.want >= 0) expected_hits.push_back(w.want[0]);
      else expected_hits.push_back(crosses_boundary(w));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $display("%0t unexpected word: expected none, actual hit=%0b", $time, rsp_hit);
            errors++;
         end else begin
            bit exp_hit;
            exp_hit = expected_hits.pop_front();
            if (exp_hit !== rsp_hit) begin
               $display("%0t hit mismatch: expected %0b, actual %0b", $time, exp_hit, rsp_hit);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   geo_word_type directed_rows[] = '{
      '{32'sh0, 32'sh0, 31'h1_0000, -32'sh2_0000, 32'sh0, 32'sh2_0000, 32'sh0, 1},
      '{32'sh0, 32'sh0, 31'h1_0000, 32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh0, 0},
      '{32'sh0, 32'sh0, 31'h4_0000, -32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh0, 0},
      '{32'sh0, 32'sh0, 31'h1_0000, 32'sh1_0000, 32'sh0, 32'sh3_0000, 32'sh0, 1},
      '{32'sh0, 32'sh0, 31'h1_0000, -32'sh2_0000, 32'sh1_0000, 32'sh2_0000,
        32'sh1_0000, 1},
      '{32'sh0, 32'sh0, 31'h1_0000, -32'sh2_0000, 32'sh2_0000, 32'sh2_0000,
        32'sh2_0000, 0},
      '{32'sh0, 32'sh0, 31'h0, -32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh0, 1},
      '{32'sh0, 32'sh0, 31'h0, -32'sh1_0000, 32'sh1, 32'sh1_0000, 32'sh1, 0},
      '{32'sh0, 32'sh0, 31'h1_0000, 32'sh2_0000, 32'sh0, 32'sh3_0000, 32'sh0, 0},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1},
      '{32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, -1},
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0, 32'sh8000_0000, 32'sh8000_0000,
        32'sh8000_0000, 32'sh7FFF_FFFF, 1},
      '{32'sh0, 32'sh0, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1},
      '{32'shFFFF_FFFF, 32'sh0, 31'h1, 32'sh0, 32'shFFFF_FFFF, 32'sh0,
        32'sh0, 1},
      '{32'sh5555_5555, 32'shAAAA_AAAA, 31'h5555_5555, 32'shAAAA_AAAA,
        32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA, -1}
   };

   initial begin
      geo_word_type w;
      int mode, kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) send_word(directed_rows[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) begin
            start <= 1'b0;
            while (expected_hits.size() != 0) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         kind = $urandom_range(0, 9);
         w.cx = rand_coord(mode);
         w.cy = rand_coord(mode);
         w.sx = rand_coord(mode);
         w.sy = rand_coord(mode);
         w.ex = rand_coord(mode);
         w.ey = rand_coord(mode);
         w.rad = (mode == 0) ? radius_type'($urandom) :
                 (mode == 1) ? radius_type'($urandom_range(0, 'h3_0000)) :
                 radius_type'($urandom_range(0, 40));
         if (kind == 0) begin
            w.ex = w.sx;
            w.ey = w.sy;
         end else if (kind == 1) begin
            w.cx = w.sx;
            w.cy = w.sy + coord_type'(w.rad);
         end else if (kind == 2 && mode == 2) begin
            w.rad = '0;
            w.cx = w.sx;
            w.cy = w.sy;
         end
         w.want = -1;
         send_word(w);
      end
      start <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sci_pkg.sv
rtl/sci_disc_unit.sv
rtl/segment_circle_intersection.sv
rtl/sci_checker.sv
sim/tb_segment_circle_intersection.sv
